### rtl/crc_keyed_lru_tile_cache_defines.svh
// assertion macros for the tile cache
`ifndef CRC_KEYED_LRU_TILE_CACHE_DEFINES_SVH
`define CRC_KEYED_LRU_TILE_CACHE_DEFINES_SVH

// property that must hold on every clock edge outside reset
`define CKL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CKL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ckl_pkg.sv
`default_nettype none
package ckl_pkg;

  localparam int unsigned NumSlotsDef = 64;
  localparam int unsigned SigBytesDef = 25;
  localparam logic [31:0] CrcPoly = 32'hEDB88320;

  typedef enum logic [1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_BUILD  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_CLAIM,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    func_e       func;
    logic [15:0] tile_size;
    logic [31:0] tile_id;
    logic [31:0] frame_stamp;
    logic [31:0] tile_key;
  } cmd_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/ckl_front.sv
`default_nettype none
module ckl_front #(
  parameter int unsigned SIG_BYTES = ckl_pkg::SigBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func_i,
  input  wire logic [7:0]  sample_byte_i,
  input  wire logic [15:0] tile_size_i,
  input  wire logic [31:0] tile_id_i,
  input  wire logic [31:0] frame_stamp_i,
  input  wire logic [31:0] key_salt_i,
  output logic             cmd_valid_o,
  output ckl_pkg::cmd_t    cmd_o,
  input  wire logic        cmd_ready_i
);
  localparam int unsigned CntW = $clog2(SIG_BYTES + 1);

  // crc is folded in as bytes arrive; zero padding at finish, one byte a cycle
  logic [31:0]   crc_q, crc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic          pad_q, pad_d;
  ckl_pkg::cmd_t hold_q, hold_d;
  logic          full_q, full_d;
  logic          acc;

  assign in_stall = pad_q || full_q;
  assign acc = in_valid && !in_stall;
  assign cmd_valid_o = full_q;
  assign cmd_o = hold_q;

  always_comb begin
    crc_d = crc_q;
    cnt_d = cnt_q;
    pad_d = pad_q;
    hold_d = hold_q;
    full_d = full_q;
    if (full_q && cmd_ready_i) begin
      full_d = 1'b0;
    end
    if (pad_q) begin
      if (cnt_q == CntW'(SIG_BYTES)) begin
        pad_d = 1'b0;
        full_d = 1'b1;
        hold_d.tile_key = ~crc_q + key_salt_i;
        crc_d = 32'hFFFFFFFF;
        cnt_d = '0;
      end else begin
        crc_d = ckl_pkg::crc_byte(crc_q, 8'd0);
        cnt_d = cnt_q + 1'b1;
      end
    end else if (acc) begin
      unique case (ckl_pkg::func_e'(func_i))
        ckl_pkg::FUNC_PUSH: begin
          if (cnt_q < CntW'(SIG_BYTES)) begin
            crc_d = ckl_pkg::crc_byte(crc_q, sample_byte_i);
            cnt_d = cnt_q + 1'b1;
          end
        end
        ckl_pkg::FUNC_CLEAR: begin
          full_d = 1'b1;
          hold_d.func = ckl_pkg::FUNC_CLEAR;
        end
        default: begin
          pad_d = 1'b1;
          hold_d.func = ckl_pkg::func_e'(func_i);
          hold_d.tile_size = tile_size_i;
          hold_d.tile_id = tile_id_i;
          hold_d.frame_stamp = frame_stamp_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= 32'hFFFFFFFF;
      cnt_q <= '0;
      pad_q <= 1'b0;
      full_q <= 1'b0;
    end else begin
      crc_q <= crc_d;
      cnt_q <= cnt_d;
      pad_q <= pad_d;
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end
endmodule
`default_nettype wire

### rtl/ckl_back.sv
`default_nettype none
module ckl_back #(
  parameter int unsigned NUM_SLOTS = ckl_pkg::NumSlotsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  wire ckl_pkg::cmd_t cmd_i,
  output logic             cmd_ready_o,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             found_o,
  output logic             was_hit_o,
  output logic [5:0]       slot_index_o,
  output logic [31:0]      tile_key_o
);
  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(NUM_SLOTS + 1);

  // one entry per slot: valid bit in flops, payload in memory
  logic [NUM_SLOTS-1:0] used_q, used_d;
  logic [31:0] mem_stamp [NUM_SLOTS];
  logic [15:0] mem_size  [NUM_SLOTS];
  logic [31:0] mem_key   [NUM_SLOTS];
  logic [31:0] rd_stamp_q;
  logic [15:0] rd_size_q;
  logic [31:0] rd_key_q;

  ckl_pkg::back_state_e st_q, st_d;
  ckl_pkg::cmd_t cmd_q, cmd_d;
  logic [CntW-1:0] addr_q, addr_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic rd_ok_q, rd_ok_d;
  logic hit_q, hit_d, have_q, have_d, free_q, free_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic [31:0] best_q, best_d;
  logic wr_en;
  logic [IdxW-1:0] wr_idx;
  logic wr_all;
  logic ovalid_q, ovalid_d, ofound_q, ofound_d, ohit_q, ohit_d;
  logic [5:0] oidx_q, oidx_d;
  logic [31:0] okey_q, okey_d;
  logic rd_used;

  assign cmd_ready_o = (st_q == ckl_pkg::ST_IDLE);
  assign out_valid = ovalid_q;
  assign found_o = ofound_q;
  assign was_hit_o = ohit_q;
  assign slot_index_o = oidx_q;
  assign tile_key_o = okey_q;
  assign rd_used = used_q[rd_idx_q];

  always_comb begin
    st_d = st_q;
    cmd_d = cmd_q;
    addr_d = addr_q;
    rd_idx_d = rd_idx_q;
    rd_ok_d = 1'b0;
    hit_d = hit_q;
    have_d = have_q;
    free_d = free_q;
    best_d = best_q;
    best_idx_d = best_idx_q;
    used_d = used_q;
    wr_en = 1'b0;
    wr_idx = best_idx_q;
    wr_all = 1'b0;
    ovalid_d = ovalid_q && out_stall;
    ofound_d = ofound_q;
    ohit_d = ohit_q;
    oidx_d = oidx_q;
    okey_d = okey_q;
    unique case (st_q)
      ckl_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          if (cmd_i.func == ckl_pkg::FUNC_CLEAR) begin
            st_d = ckl_pkg::ST_CLEAR;
          end else begin
            st_d = ckl_pkg::ST_SCAN;
            addr_d = '0;
            hit_d = 1'b0;
            have_d = 1'b0;
            free_d = 1'b0;
            best_d = cmd_i.frame_stamp;
          end
        end
      end
      ckl_pkg::ST_CLEAR: begin
        wr_all = 1'b1;
        used_d = '0;
        st_d = ckl_pkg::ST_IDLE;
      end
      ckl_pkg::ST_SCAN: begin
        // read issue
        if (addr_q < CntW'(NUM_SLOTS)) begin
          rd_idx_d = addr_q[IdxW-1:0];
          rd_ok_d = 1'b1;
          addr_d = addr_q + 1'b1;
        end
        // evaluate previous read
        if (rd_ok_q && !hit_q) begin
          if (rd_used && rd_size_q == cmd_q.tile_size && rd_key_q == cmd_q.tile_key) begin
            hit_d = 1'b1;
            best_idx_d = rd_idx_q;
          end else if (!free_q) begin
            if (!rd_used) begin
              free_d = 1'b1;
              have_d = 1'b1;
              best_idx_d = rd_idx_q;
            end else if (rd_stamp_q < best_q) begin
              best_d = rd_stamp_q;
              have_d = 1'b1;
              best_idx_d = rd_idx_q;
            end
          end
        end
        if (hit_d || (!rd_ok_d && !(rd_ok_q && addr_q < CntW'(NUM_SLOTS)))) begin
          if (hit_d || addr_q == CntW'(NUM_SLOTS) && !rd_ok_d) begin
            st_d = ckl_pkg::ST_CLAIM;
          end
        end
      end
      ckl_pkg::ST_CLAIM: begin
        if (!ovalid_q || !out_stall) begin
          ovalid_d = 1'b1;
          okey_d = cmd_q.tile_key;
          ohit_d = hit_q;
          if (hit_q) begin
            wr_en = 1'b1;
            ofound_d = 1'b1;
            oidx_d = 6'(best_idx_q);
          end else if (cmd_q.func == ckl_pkg::FUNC_BUILD && have_q) begin
            wr_en = 1'b1;
            used_d[best_idx_q] = 1'b1;
            ofound_d = 1'b1;
            oidx_d = 6'(best_idx_q);
          end else begin
            ofound_d = 1'b0;
            oidx_d = '0;
          end
          st_d = ckl_pkg::ST_IDLE;
        end
      end
      default: st_d = ckl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_stamp_q <= mem_stamp[rd_idx_d];
    rd_size_q <= mem_size[rd_idx_d];
    rd_key_q <= mem_key[rd_idx_d];
    if (wr_en) begin
      mem_stamp[wr_idx] <= cmd_q.frame_stamp;
      if (!hit_q) begin
        mem_size[wr_idx] <= cmd_q.tile_size;
        mem_key[wr_idx] <= cmd_q.tile_key;
      end
    end
    cmd_q <= cmd_d;
    rd_idx_q <= rd_idx_d;
    best_q <= best_d;
    best_idx_q <= best_idx_d;
    ofound_q <= ofound_d;
    ohit_q <= ohit_d;
    oidx_q <= oidx_d;
    okey_q <= okey_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ckl_pkg::ST_IDLE;
      used_q <= '0;
      addr_q <= '0;
      rd_ok_q <= 1'b0;
      hit_q <= 1'b0;
      have_q <= 1'b0;
      free_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      used_q <= wr_all ? '0 : used_d;
      addr_q <= addr_d;
      rd_ok_q <= rd_ok_d;
      hit_q <= hit_d;
      have_q <= have_d;
      free_q <= free_d;
      ovalid_q <= ovalid_d;
    end
  end
endmodule
`default_nettype wire

### rtl/crc_keyed_lru_tile_cache.sv
// push: each sample byte is folded into the crc as it arrives
// finish: pads the signature to its full length with zero bytes, then walks
// the slots one a cycle through the tag memory read port, stopping early on a hit
// reset empties all slots at once through per-slot valid flops; key_salt resets to 0
`default_nettype none
`include "crc_keyed_lru_tile_cache_defines.svh"
module crc_keyed_lru_tile_cache #(
  parameter int unsigned NUM_SLOTS = ckl_pkg::NumSlotsDef,
  parameter int unsigned SIG_BYTES = ckl_pkg::SigBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func_i,
  input  wire logic [7:0]  sample_byte_i,
  input  wire logic [15:0] tile_size_i,
  input  wire logic [31:0] tile_id_i,
  input  wire logic [31:0] frame_stamp_i,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data_i,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             found_o,
  output logic             was_hit_o,
  output logic [5:0]       slot_index_o,
  output logic [31:0]      tile_key_o
);
  logic [31:0]   salt_q;
  logic          cmd_valid, cmd_ready;
  ckl_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      salt_q <= '0;
    end else if (cfg_valid) begin
      salt_q <= cfg_data_i;
    end
  end

  ckl_front #(.SIG_BYTES(SIG_BYTES)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .func_i, .sample_byte_i,
    .tile_size_i, .tile_id_i, .frame_stamp_i, .key_salt_i(salt_q),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready)
  );

  ckl_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_ready_o(cmd_ready),
    .out_valid, .out_stall, .found_o, .was_hit_o, .slot_index_o, .tile_key_o
  );

  `CKL_ASSERT(a_hit_found, clk_i, rst_ni, !out_valid || !was_hit_o || found_o, "hit without found")
  `CKL_ASSERT(a_miss_idx, clk_i, rst_ni, !out_valid || found_o || slot_index_o == 6'd0, "index on miss")
  `CKL_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && out_stall, out_valid && $stable(tile_key_o), "result lost")
endmodule
`default_nettype wire

### tb/sv/testbench.sv
module testbench;

  localparam int NSLOT = 64;
  localparam int NSIG = 25;
  localparam int RAND_ITEMS = 640;
  localparam int WATCH_LIMIT = 20000;
  localparam int SETTLE = 200;

  typedef struct packed {
    logic        found;
    logic        was_hit;
    logic [5:0]  slot_index;
    logic [31:0] tile_key;
  } tile_res_t;

  typedef struct packed {
    ckl_pkg::func_e func;
    logic [7:0]     sample_byte;
    logic [15:0]    tile_size;
    logic [31:0]    tile_id;
    logic [31:0]    frame_stamp;
  } tile_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func_i = '0;
  logic [7:0] sample_byte_i = '0;
  logic [15:0] tile_size_i = '0;
  logic [31:0] tile_id_i = '0;
  logic [31:0] frame_stamp_i = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data_i = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic found_o, was_hit_o;
  logic [5:0] slot_index_o;
  logic [31:0] tile_key_o;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  crc_keyed_lru_tile_cache i_dut (
    .clk_i, .rst_ni, .in_valid, .in_stall, .func_i, .sample_byte_i, .tile_size_i,
    .tile_id_i, .frame_stamp_i, .cfg_valid, .cfg_ready, .cfg_data_i, .out_valid,
    .out_stall, .found_o, .was_hit_o, .slot_index_o, .tile_key_o
  );

  // predictor state
  logic [31:0] salt_q;
  logic [31:0] sl_data [NSLOT];
  logic [31:0] sl_stamp [NSLOT];
  logic [15:0] sl_size [NSLOT];
  logic [31:0] sl_key [NSLOT];
  logic [7:0] sig_buf [NSIG];
  int sig_cnt;

  tile_res_t res_q[$];
  // typed expectation travels with the transaction it belongs to
  bit typed_has = 1'b0;
  tile_res_t typed_exp = '0;
  bit typed_q[$];
  tile_res_t typed_exp_q[$];
  int errors = 0;
  int n_in = 0, n_out = 0, n_hit = 0, n_fail = 0;
  int n_sent = 0;
  int idle_cnt = 0;
  bit hold_long = 1'b0;

  function automatic logic [31:0] sig_key();
    logic [31:0] c;
    c = 32'hFFFF_FFFF;
    for (int i = 0; i < NSIG; i++) begin
      c ^= {24'd0, sig_buf[i]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
    end
    return ~c + salt_q;
  endfunction

  task automatic clear_model();
    for (int i = 0; i < NSLOT; i++) begin
      sl_data[i] = '0;
      sl_stamp[i] = '0;
      sl_size[i] = '0;
      sl_key[i] = '0;
    end
  endtask

  task automatic predict_tile(input tile_req_t r);
    tile_res_t e;
    logic [31:0] best;
    bit have;
    int idx;
    case (r.func)
      ckl_pkg::FUNC_PUSH: begin
        if (sig_cnt < NSIG) begin
          sig_buf[sig_cnt] = r.sample_byte;
          sig_cnt++;
        end
      end
      ckl_pkg::FUNC_CLEAR: clear_model();
      default: begin
        e = '0;
        e.tile_key = sig_key();
        for (int i = 0; i < NSIG; i++) sig_buf[i] = '0;
        sig_cnt = 0;
        idx = 0;
        for (int i = 0; i < NSLOT; i++) begin
          if (sl_data[i] != 0 && sl_size[i] == r.tile_size && sl_key[i] == e.tile_key) begin
            sl_stamp[i] = r.frame_stamp;
            e.found = 1'b1;
            e.was_hit = 1'b1;
            idx = i;
            break;
          end
        end
        if (!e.was_hit && r.func == ckl_pkg::FUNC_BUILD) begin
          have = 1'b0;
          best = r.frame_stamp;
          for (int i = 0; i < NSLOT; i++) begin
            if (sl_data[i] == 0) begin
              idx = i;
              have = 1'b1;
              break;
            end
            if (sl_stamp[i] < best) begin
              best = sl_stamp[i];
              idx = i;
              have = 1'b1;
            end
          end
          if (have) begin
            sl_key[idx] = e.tile_key;
            sl_size[idx] = r.tile_size;
            sl_data[idx] = (r.tile_id != 0) ? r.tile_id : 32'd1;
            sl_stamp[idx] = r.frame_stamp;
            e.found = 1'b1;
          end
        end
        e.slot_index = e.found ? idx[5:0] : 6'd0;
        res_q.push_back(e);
        typed_q.push_back(typed_has);
        typed_exp_q.push_back(typed_exp);
      end
    endcase
  endtask

  // acceptance of input transactions feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall) begin
      predict_tile('{ckl_pkg::func_e'(func_i), sample_byte_i, tile_size_i, tile_id_i,
                     frame_stamp_i});
      n_in++;
    end
  end

  // result checking
  always @(posedge clk_i) begin
    tile_res_t a, e, t;
    bit t_has;
    if (rst_ni && out_valid && !out_stall) begin
      a = '{found_o, was_hit_o, slot_index_o, tile_key_o};
      n_out++;
      if (res_q.size() == 0) begin
        $display("%0t: unexpected result exp none got %h", $time, a);
        errors++;
      end else begin
        e = res_q.pop_front();
        t_has = typed_q.pop_front();
        t = typed_exp_q.pop_front();
        if (a.found && a.was_hit) n_hit++;
        if (!a.found) n_fail++;
        if (a.found !== e.found) begin
          $display("%0t: found exp %h got %h", $time, e.found, a.found);
          errors++;
        end
        if (a.was_hit !== e.was_hit) begin
          $display("%0t: was_hit exp %h got %h", $time, e.was_hit, a.was_hit);
          errors++;
        end
        if (a.slot_index !== e.slot_index) begin
          $display("%0t: slot_index exp %h got %h", $time, e.slot_index, a.slot_index);
          errors++;
        end
        if (a.tile_key !== e.tile_key) begin
          $display("%0t: tile_key exp %h got %h", $time, e.tile_key, a.tile_key);
          errors++;
        end
        // typed rows fix found, hit and index; the key comes from the predictor
        if (t_has && {a.found, a.was_hit, a.slot_index} !==
            {t.found, t.was_hit, t.slot_index}) begin
          $display("%0t: directed exp %h got %h", $time,
                   {t.found, t.was_hit, t.slot_index}, {a.found, a.was_hit, a.slot_index});
          errors++;
        end
      end
    end
  end

  // receiver stall
  initial begin
    int w;
    out_stall <= 1'b1;
    wait (rst_ni);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        for (int i = 0; i < 400; i++) @(posedge clk_i);
        hold_long = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WATCH_LIMIT) begin
      $display("crc_keyed_lru_tile_cache: mismatch");
      $finish;
    end
  end

  bit gaps_on = 1'b1;

  task automatic send_tile(input tile_req_t r);
    int w;
    w = gaps_on ? $urandom_range(0, 5) : 0;
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    func_i <= r.func;
    sample_byte_i <= r.sample_byte;
    tile_size_i <= r.tile_size;
    tile_id_i <= r.tile_id;
    frame_stamp_i <= r.frame_stamp;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (res_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_salt(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    salt_q = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic tile_req_t mk(ckl_pkg::func_e f, logic [7:0] b, logic [15:0] s,
                                   logic [31:0] id, logic [31:0] fr);
    tile_req_t r;
    r.func = f;
    r.sample_byte = b;
    r.tile_size = s;
    r.tile_id = id;
    r.frame_stamp = fr;
    return r;
  endfunction

  // directed rows; found, hit and index typed in for the first rows on an empty cache
  tile_req_t dir_tab[$];
  tile_res_t dir_exp[$];
  bit dir_has[$];

  initial begin
    logic [31:0] frame;
    int pick;
    int lim;
    for (int i = 0; i < NSIG; i++) sig_buf[i] = '0;
    sig_cnt = 0;
    salt_q = '0;
    clear_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty signature, nothing stored: lookup misses
    dir_tab.push_back(mk(ckl_pkg::FUNC_LOOKUP, 8'h00, 16'h0000, 32'h0, 32'h0));
    dir_has.push_back(1'b1);
    dir_exp.push_back(tile_res_t'{1'b0, 1'b0, 6'd0, 32'h0});
    // build claims the first free slot
    dir_tab.push_back(mk(ckl_pkg::FUNC_BUILD, 8'h00, 16'hFFFF, 32'h0, 32'hFFFF_FFFF));
    dir_has.push_back(1'b1);
    dir_exp.push_back(tile_res_t'{1'b1, 1'b0, 6'd0, 32'h0});
    // same signature and size hits that slot
    dir_tab.push_back(mk(ckl_pkg::FUNC_BUILD, 8'h00, 16'hFFFF, 32'h5, 32'h0000_0001));
    dir_has.push_back(1'b1);
    dir_exp.push_back(tile_res_t'{1'b1, 1'b1, 6'd0, 32'h0});
    dir_tab.push_back(mk(ckl_pkg::FUNC_LOOKUP, 8'h00, 16'hFFFF, 32'h0, 32'h7));
    for (int i = 0; i < 27; i++)
      dir_tab.push_back(mk(ckl_pkg::FUNC_PUSH, (i % 2) ? 8'hFF : 8'h00, 16'h0, 32'h0,
                           32'h0));
    dir_tab.push_back(mk(ckl_pkg::FUNC_BUILD, 8'h0, 16'h0, 32'hFFFF_FFFF, 32'h2));
    dir_tab.push_back(mk(ckl_pkg::FUNC_CLEAR, 8'h0, 16'h0, 32'h0, 32'h0));
    dir_tab.push_back(mk(ckl_pkg::FUNC_LOOKUP, 8'h0, 16'hFFFF, 32'h0, 32'h9));
    while (dir_has.size() < dir_tab.size()) dir_has.push_back(1'b0);
    while (dir_exp.size() < dir_tab.size()) dir_exp.push_back(tile_res_t'(0));

    foreach (dir_tab[i]) begin
      typed_has <= dir_has[i];
      typed_exp <= dir_exp[i];
      send_tile(dir_tab[i]);
    end
    drain();

    // fill all slots with one frame so that a build at the same frame fails
    for (int i = 0; i < NSLOT + 1; i++) begin
      send_tile(mk(ckl_pkg::FUNC_PUSH, i[7:0], 16'h0, 32'h0, 32'h0));
      send_tile(mk(ckl_pkg::FUNC_BUILD, 8'h0, 16'h1, 32'(i), 32'h10));
    end
    send_tile(mk(ckl_pkg::FUNC_PUSH, 8'hAA, 16'h0, 32'h0, 32'h0));
    send_tile(mk(ckl_pkg::FUNC_BUILD, 8'h0, 16'h1, 32'h1, 32'h11));
    drain();

    // random phases with several salts, extremes included
    frame = 32'h100;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_salt(32'hFFFF_FFFF);
        1: write_salt(32'h0);
        default: write_salt($urandom);
      endcase
      gaps_on = (ph != 2);
      lim = n_sent + RAND_ITEMS / 5;
      for (int k = 0; n_sent < lim; k++) begin
        pick = $urandom_range(0, 99);
        if (ph == 3 && k == 2) hold_long = 1'b1;
        if (ph == 1 && k == 3) drain();
        if (pick < 80) begin
          // a signature from a small pool so that hits recur
          int len;
          int seed;
          len = $urandom_range(0, 3) == 0 ? $urandom_range(24, 27) : $urandom_range(0, 4);
          seed = $urandom_range(0, 5);
          for (int j = 0; j < len; j++)
            send_tile(mk(ckl_pkg::FUNC_PUSH, 8'((seed * 37 + j * 11) % 256), 16'h0, 32'h0,
                         32'h0));
          if ($urandom_range(0, 9) == 0) frame = frame + $urandom_range(0, 3);
          else frame = frame + 1;
          if ($urandom_range(0, 19) == 0) frame = $urandom;
          send_tile(mk($urandom_range(0, 3) == 0 ? ckl_pkg::FUNC_LOOKUP : ckl_pkg::FUNC_BUILD,
                       8'h0,
                       $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1)),
                       $urandom_range(0, 7) == 0 ? 32'h0 : $urandom, frame));
        end else if (pick < 83) begin
          send_tile(mk(ckl_pkg::FUNC_CLEAR, 8'($urandom), 16'($urandom), $urandom,
                       $urandom));
        end else begin
          send_tile(mk(ckl_pkg::func_e'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                       $urandom, $urandom));
        end
      end
      drain();
    end

    $display("ran %0d transactions in, %0d results (%0d hits, %0d not found)",
             n_in, n_out, n_hit, n_fail);
    $display("covered salt extremes, lru eviction, full cache and clears");
    if (errors == 0) begin
      $display("crc_keyed_lru_tile_cache: match");
    end else begin
      $display("crc_keyed_lru_tile_cache: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/ckl_pkg.sv
rtl/ckl_front.sv
rtl/ckl_back.sv
rtl/crc_keyed_lru_tile_cache.sv
tb/sv/testbench.sv
